/* rtl/core/assert_macros.svh */
// assertion macros shared by the renderer rtl
// no dependencies; included by the modules that carry checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/sbr_pkg.sv */
// types, constants and word helpers for the scanline bitplane renderer
// no dependencies; used by every module in rtl/core
package sbr_pkg;

    localparam int WORDS_PER_LINE = 6;
    localparam logic [2:0] LAST_WORD = 3'(WORDS_PER_LINE - 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_END = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RESTART   = 1'b1;

    localparam logic [9:0] FRAME_END_RESET = 10'd600;
    localparam logic [6:0] RESTART_RESET   = 7'h64;
    localparam logic signed [10:0] LINE_MAX = 11'sd1023;

    typedef enum logic [1:0] {
        MODE_LINE    = 2'd0,
        MODE_RESTART = 2'd1,
        MODE_BRICK   = 2'd2
    } mode_t;

    localparam logic [2:0] COL_BLACK   = 3'b000;
    localparam logic [2:0] COL_RED     = 3'b100;
    localparam logic [2:0] COL_MAGENTA = 3'b101;
    localparam logic [2:0] COL_YELLOW  = 3'b110;
    localparam logic [2:0] COL_BLUE    = 3'b001;
    localparam logic [2:0] COL_CYAN    = 3'b011;
    localparam logic [2:0] COL_GREEN   = 3'b010;

    localparam logic [15:0] RED_WALL_L = 16'h0078;
    localparam logic [15:0] GRN_WALL_L = 16'h0780;
    localparam logic [15:0] BLU_WALL_L = 16'h7800;
    localparam logic [15:0] RED_WALL_R = 16'h0F00;
    localparam logic [15:0] GRN_WALL_R = 16'hF000;
    localparam logic [15:0] BLU_WALL_R = 16'h000F;

    localparam logic [31:0] BAT_PAT  = 32'hFFE0_0000;
    localparam logic [31:0] BALL_PAT = 32'h8000_0000;

    // sprite positions are kept as red pixel + 256
    localparam logic [8:0] BAT_P_OFS  = 9'd269;
    localparam logic [8:0] BALL_P_OFS = 9'd141;
    localparam logic [8:0] GRN_SKEW   = 9'd4;
    localparam logic [8:0] BLU_SKEW   = 9'd8;

    typedef struct packed {
        logic       frame_end;
        logic [2:0] color;
        logic [7:0] bricks;
        logic       bat_en;
        logic [8:0] bat_p;
        logic       ball_en;
        logic [8:0] ball_p;
    } line_desc_t;

    // two bricks of one pair, left brick in the upper byte
    function automatic logic [15:0] brick_pat(input logic [7:0] bricks,
                                              input logic [1:0] pair);
        logic [7:0] sh;
        sh = bricks << {pair, 1'b0};
        return {1'b0, {7{sh[7]}}, 1'b0, {7{sh[6]}}};
    endfunction

    // part of a 32-pixel sprite pattern at position p that lands in word k
    function automatic logic [15:0] sprite_word(input logic [8:0]  p,
                                                input logic [2:0]  k,
                                                input logic [31:0] pat);
        logic [31:0] v;
        logic [4:0]  wk;
        logic [15:0] res;
        v   = pat >> p[3:0];
        wk  = {2'b10, k};
        res = '0;
        if (p[8:4] == wk)
        begin
            res = v[31:16];
        end
        else if (p[8:4] + 5'd1 == wk)
        begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage

/* rtl/core/sbr_queue.sv */
// two-entry line descriptor queue between front and back end
// depends on sbr_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  sbr_pkg::line_desc_t push_desc,
    output logic                ready,
    input  logic                pop,
    output logic                valid,
    output sbr_pkg::line_desc_t head_desc
);
    import sbr_pkg::*;

    localparam logic [1:0] QDEPTH = 2'd2;

    line_desc_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign ready     = (count_reg != QDEPTH);
    assign valid     = (count_reg != 2'd0);
    assign head_desc = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

    `ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, count_reg != QDEPTH, "push into full queue")
    `ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, count_reg != 2'd0, "pop from empty queue")

endmodule

/* rtl/core/sbr_front.sv */
// front end: takes input beats, keeps line counter, brick rows and config
// classifies each line tick into a line descriptor; depends on sbr_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbr_front #(
    parameter int BRICK_ROW_COUNT = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  sbr_pkg::mode_t                    mode,
    input  logic [6:0]                        bat_pos,
    input  logic signed [8:0]                 ball_pos_x,
    input  logic signed [10:0]                ball_pos_y,
    input  logic [3:0]                        row_index,
    input  logic [7:0]                        row_bits,
    input  logic                              q_ready,
    output logic                              q_push,
    output sbr_pkg::line_desc_t               q_desc
);
    import sbr_pkg::*;

    localparam int ROW_W = (BRICK_ROW_COUNT > 1) ? $clog2(BRICK_ROW_COUNT) : 1;

    logic [9:0]         frame_end_reg, frame_end_next;
    logic [6:0]         restart_reg, restart_next;
    logic signed [10:0] line_reg, line_next;
    logic [7:0]         brick_reg [BRICK_ROW_COUNT];

    logic               accept;
    logic               brick_we;
    logic signed [10:0] line_inc;
    logic signed [10:0] restart_ext;
    logic signed [11:0] ball_diff;
    logic [3:0]         row;
    logic               in_band;
    logic [2:0]         color;
    logic [7:0]         bricks;

    assign in_ready    = q_ready;
    assign accept      = in_valid && q_ready;
    assign restart_ext = {{4{restart_reg[6]}}, restart_reg};
    assign line_inc    = (line_reg == LINE_MAX) ? line_reg : line_reg + 11'sd1;

    always_comb
    begin
        frame_end_next = frame_end_reg;
        restart_next   = restart_reg;
        if (cfg_wr_en && cfg_index == REG_FRAME_END)
        begin
            frame_end_next = cfg_data;
        end
        if (cfg_wr_en && cfg_index == REG_RESTART)
        begin
            restart_next = cfg_data[6:0];
        end
    end

    always_comb
    begin
        line_next = line_reg;
        brick_we  = 1'b0;
        q_push    = 1'b0;
        if (accept)
        begin
            case (mode)
                MODE_LINE:
                begin
                    line_next = line_inc;
                    q_push    = 1'b1;
                end
                MODE_RESTART:
                begin
                    line_next = restart_ext;
                end
                MODE_BRICK:
                begin
                    brick_we = (int'(row_index) < BRICK_ROW_COUNT);
                end
                default:
                begin
                    line_next = line_reg;
                end
            endcase
        end
    end

    // band color by line, black in the mortar lines
    always_comb
    begin
        if (line_inc > 11'sd256)
        begin
            color = COL_BLACK;
        end
        else if (line_inc > 11'sd224)
        begin
            color = COL_GREEN;
        end
        else if (line_inc > 11'sd192)
        begin
            color = COL_CYAN;
        end
        else if (line_inc > 11'sd160)
        begin
            color = COL_BLUE;
        end
        else if (line_inc > 11'sd128)
        begin
            color = COL_YELLOW;
        end
        else if (line_inc > 11'sd96)
        begin
            color = COL_MAGENTA;
        end
        else if (line_inc > 11'sd64)
        begin
            color = COL_RED;
        end
        else
        begin
            color = COL_BLACK;
        end
        if (line_inc[3:2] == 2'b00)
        begin
            color = COL_BLACK;
        end
    end

    always_comb
    begin
        in_band = !line_inc[10] && line_inc[9:8] == 2'b00 && line_inc[7:6] != 2'b00;
        row     = line_inc[7:4] - 4'd4;
        bricks  = 8'h00;
        if (in_band && int'(row) < BRICK_ROW_COUNT)
        begin
            bricks = brick_reg[row[ROW_W-1:0]];
        end
    end

    always_comb
    begin
        ball_diff = {line_inc[10], line_inc} - {ball_pos_y[10], ball_pos_y};
        q_desc.frame_end = !line_inc[10] && line_inc[9:0] == frame_end_reg;
        q_desc.color     = color;
        q_desc.bricks    = bricks;
        q_desc.bat_en    = !line_inc[10] && line_inc[9:3] == 7'h40;
        q_desc.bat_p     = {3'b000, bat_pos[6:1]} + BAT_P_OFS;
        q_desc.ball_en   = (ball_diff >= -12'sd4) && (ball_diff <= 12'sd3);
        q_desc.ball_p    = {1'b0, ~ball_pos_x[8], ball_pos_x[7:1]} + BALL_P_OFS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_end_reg <= FRAME_END_RESET;
            restart_reg   <= RESTART_RESET;
            line_reg      <= '0;
            for (int i = 0; i < BRICK_ROW_COUNT; i++)
            begin
                brick_reg[i] <= 8'hFF;
            end
        end
        else
        begin
            frame_end_reg <= frame_end_next;
            restart_reg   <= restart_next;
            line_reg      <= line_next;
            if (brick_we)
            begin
                brick_reg[row_index[ROW_W-1:0]] <= row_bits;
            end
        end
    end

    `ASSERT_NEXT(a_restart_load, clk, rst_n, accept && mode == MODE_RESTART, line_reg == $past(restart_ext), "restart did not load line counter")

endmodule

/* rtl/core/sbr_back.sv */
// back end: expands one line descriptor into six bitplane words, one a cycle while the output is not stalled
// holds the output register; depends on sbr_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  sbr_pkg::line_desc_t q_desc,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [2:0]          word_index,
    output logic [15:0]         red_word,
    output logic [15:0]         green_word,
    output logic [15:0]         blue_word,
    output logic                last_word,
    output logic                frame_end
);
    import sbr_pkg::*;

    logic [2:0]  word_cnt_reg, word_cnt_next;
    logic        out_valid_reg, out_valid_next;
    logic [2:0]  index_reg;
    logic [15:0] red_reg, green_reg, blue_reg;
    logic        last_reg, frame_end_reg;

    logic        advance;
    logic [2:0]  k, kp;
    logic [15:0] pat_cur, pat_prev;
    logic [15:0] prev_r, cur_g, prev_g, cur_b, prev_b;
    logic [15:0] red_w, green_w, blue_w;

    assign k       = word_cnt_reg;
    assign kp      = word_cnt_reg - 3'd1;
    assign advance = q_valid && (!out_valid_reg || out_ready);
    assign q_pop   = advance && (word_cnt_reg == LAST_WORD);

    always_comb
    begin
        pat_cur  = brick_pat(q_desc.bricks, k[1:0]);
        pat_prev = brick_pat(q_desc.bricks, kp[1:0]);
        prev_r   = pat_prev & {16{q_desc.color[2]}};
        prev_g   = pat_prev & {16{q_desc.color[1]}};
        cur_g    = pat_cur & {16{q_desc.color[1]}};
        prev_b   = pat_prev & {16{q_desc.color[0]}};
        cur_b    = pat_cur & {16{q_desc.color[0]}};

        // walls and bricks; green and blue bricks straddle word borders
        case (k)
            3'd0:
            begin
                red_w   = RED_WALL_L;
                green_w = GRN_WALL_L | {12'h000, cur_g[15:12]};
                blue_w  = BLU_WALL_L | {8'h00, cur_b[15:8]};
            end
            3'd1, 3'd2, 3'd3:
            begin
                red_w   = prev_r;
                green_w = {prev_g[11:0], 4'h0} | {12'h000, cur_g[15:12]};
                blue_w  = {prev_b[7:0], 8'h00} | {8'h00, cur_b[15:8]};
            end
            3'd4:
            begin
                red_w   = prev_r;
                green_w = {prev_g[11:0], 4'h0};
                blue_w  = {prev_b[7:0], 8'h00} | BLU_WALL_R;
            end
            3'd5:
            begin
                red_w   = RED_WALL_R;
                green_w = GRN_WALL_R;
                blue_w  = 16'h0000;
            end
            default:
            begin
                red_w   = 16'h0000;
                green_w = 16'h0000;
                blue_w  = 16'h0000;
            end
        endcase

        if (q_desc.bat_en)
        begin
            red_w   = red_w | sprite_word(q_desc.bat_p, k, BAT_PAT);
            green_w = green_w | sprite_word(q_desc.bat_p - GRN_SKEW, k, BAT_PAT);
            blue_w  = blue_w | sprite_word(q_desc.bat_p - BLU_SKEW, k, BAT_PAT);
        end
        if (q_desc.ball_en)
        begin
            red_w   = red_w | sprite_word(q_desc.ball_p, k, BALL_PAT);
            green_w = green_w | sprite_word(q_desc.ball_p - GRN_SKEW, k, BALL_PAT);
            blue_w  = blue_w | sprite_word(q_desc.ball_p - BLU_SKEW, k, BALL_PAT);
        end
    end

    always_comb
    begin
        word_cnt_next  = word_cnt_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            word_cnt_next  = (word_cnt_reg == LAST_WORD) ? 3'd0 : word_cnt_reg + 3'd1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_cnt_reg  <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            word_cnt_reg  <= word_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            index_reg     <= k;
            red_reg       <= red_w;
            green_reg     <= green_w;
            blue_reg      <= blue_w;
            last_reg      <= (k == LAST_WORD);
            frame_end_reg <= q_desc.frame_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign word_index = index_reg;
    assign red_word   = red_reg;
    assign green_word = green_reg;
    assign blue_word  = blue_reg;
    assign last_word  = last_reg;
    assign frame_end  = frame_end_reg;

    `ASSERT_ALWAYS(a_word_cnt_range, clk, rst_n, word_cnt_reg <= LAST_WORD, "word counter out of range")
    `ASSERT_IMPLY(a_last_matches_index, clk, rst_n, out_valid_reg && last_reg, index_reg == LAST_WORD, "last flag on wrong word")

endmodule

/* rtl/core/scanline_bitplane_renderer.sv */
// top level of the scanline bitplane renderer: front end, descriptor queue, back end
// depends on sbr_pkg, sbr_front, sbr_queue and sbr_back
//
//  channel   dir  handshake                    payload
//  cfg       in   cfg_wr_en                    cfg_index, cfg_data
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: input fields, tuser: mode
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: word fields, tlast, tuser
//
// a line tick makes six beats, one per cycle while m_axis_tready stays high;
// the back end's single word generator produces them in turn
// restart and brick writes are handled in the front end and make no beats
// a two-line queue lets the front take new beats while the back end is busy
// reset clears the line counter, sets all brick rows and config to defaults
// output beats stall on m_axis_tready; s_axis_tready drops only when the queue is full
module scanline_bitplane_renderer #(
    parameter int BRICK_ROW_COUNT = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sbr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // bat_pos[6:0], ball_pos_x[15:7], ball_pos_y[26:16], row_index[30:27],
    // row_bits[38:31], zero pad
    input  logic [39:0]                    s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // word_index[2:0], red_word[18:3], green_word[34:19], blue_word[50:35], zero pad
    output logic [55:0]                    m_axis_tdata,
    output logic                           m_axis_tlast,
    // frame_end[0]
    output logic [0:0]                     m_axis_tuser
);
    import sbr_pkg::*;

    logic       q_push, q_ready, q_pop, q_valid;
    line_desc_t push_desc, head_desc;
    logic [2:0] word_index;
    logic [15:0] red_word, green_word, blue_word;
    logic       frame_end;

    sbr_front #(
        .BRICK_ROW_COUNT(BRICK_ROW_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .mode       (mode_t'(s_axis_tuser)),
        .bat_pos    (s_axis_tdata[6:0]),
        .ball_pos_x (s_axis_tdata[15:7]),
        .ball_pos_y (s_axis_tdata[26:16]),
        .row_index  (s_axis_tdata[30:27]),
        .row_bits   (s_axis_tdata[38:31]),
        .q_ready    (q_ready),
        .q_push     (q_push),
        .q_desc     (push_desc)
    );

    sbr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_desc (push_desc),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head_desc (head_desc)
    );

    sbr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_desc     (head_desc),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .word_index (word_index),
        .red_word   (red_word),
        .green_word (green_word),
        .blue_word  (blue_word),
        .last_word  (m_axis_tlast),
        .frame_end  (frame_end)
    );

    assign m_axis_tdata = {5'b00000, blue_word, green_word, red_word, word_index};
    assign m_axis_tuser = frame_end;

endmodule

/* bench/tb_scanline_bitplane_renderer.sv */
// self-checking testbench for scanline_bitplane_renderer
// keeps its own line renderer, queues the expected word beats and compares every output beat
// depends on sbr_pkg and the renderer rtl only
module tb_scanline_bitplane_renderer;
    timeunit 1ns;
    timeprecision 1ps;

    import sbr_pkg::*;

    localparam int          NUM_WORDS    = 6;
    localparam int          NUM_ROWS     = 12;
    localparam int          LINE_TOP     = 1023;
    localparam int          DRAIN_CYCLES = 20;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;

    localparam logic [2:0]  C_BLACK   = 3'b000;
    localparam logic [2:0]  C_RED     = 3'b100;
    localparam logic [2:0]  C_MAGENTA = 3'b101;
    localparam logic [2:0]  C_YELLOW  = 3'b110;
    localparam logic [2:0]  C_BLUE    = 3'b001;
    localparam logic [2:0]  C_CYAN    = 3'b011;
    localparam logic [2:0]  C_GREEN   = 3'b010;

    localparam logic [15:0] R_LEFT  = 16'h0078;
    localparam logic [15:0] G_LEFT  = 16'h0780;
    localparam logic [15:0] B_LEFT  = 16'h7800;
    localparam logic [15:0] R_RIGHT = 16'h0F00;
    localparam logic [15:0] G_RIGHT = 16'hF000;
    localparam logic [15:0] B_RIGHT = 16'h000F;
    localparam logic [15:0] BRICK_L = 16'h7F00;
    localparam logic [15:0] BRICK_R = 16'h007F;
    localparam logic [31:0] BAT_SHAPE  = 32'hFFE0_0000;
    localparam logic [31:0] BALL_SHAPE = 32'h8000_0000;

    typedef logic [NUM_WORDS-1:0][15:0] plane_t;

    typedef struct {
        logic [1:0]  mode;
        logic [6:0]  bat;
        logic [8:0]  ball_x;
        logic [10:0] ball_y;
        logic [3:0]  row;
        logic [7:0]  bricks;
    } line_cmd_t;

    typedef struct {
        logic [2:0]  idx;
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        last;
        logic        fe;
    } word_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [55:0]           m_axis_tdata;
    logic                  m_axis_tlast;
    logic [0:0]            m_axis_tuser;

    // predictor state
    int          scan_line;
    logic [7:0]  row_mask [NUM_ROWS];
    logic [9:0]  frame_end_cfg;
    logic [6:0]  restart_cfg;
    word_beat_t  words_due [$];

    // stimulus state
    line_cmd_t   cmd_q [$];
    line_cmd_t   cur_cmd;
    bit          cmd_taken;
    int          send_gap;
    int          hold_left;
    int          idle_pct;
    int          stim_line;
    int          bad_beats;
    int          cycle_count;

    scanline_bitplane_renderer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic plane_t overlay(input plane_t p, input int a, input logic [31:0] shape);
        int          w;
        logic [31:0] v;
        w = ((a + 256) >>> 4) - 16;
        v = shape >> ((a + 256) & 15);
        if (w >= 0 && w < NUM_WORDS)
        begin
            p[w] = p[w] | v[31:16];
        end
        if (w + 1 >= 0 && w + 1 < NUM_WORDS)
        begin
            p[w + 1] = p[w + 1] | v[15:0];
        end
        return p;
    endfunction

    task automatic render_line(input line_cmd_t c);
        plane_t      r;
        plane_t      g;
        plane_t      b;
        logic [2:0]  colour;
        logic [7:0]  bricks;
        logic [15:0] pat;
        logic [15:0] pr;
        logic [15:0] pg;
        logic [15:0] pb;
        int          bat_a;
        int          bx;
        int          by;
        int          rx;
        logic        fe;
        word_beat_t  wb;
        if (scan_line < LINE_TOP)
        begin
            scan_line++;
        end
        fe = (scan_line == int'(frame_end_cfg));

        if (scan_line > 'h100)      colour = C_BLACK;
        else if (scan_line > 'hE0)  colour = C_GREEN;
        else if (scan_line > 'hC0)  colour = C_CYAN;
        else if (scan_line > 'hA0)  colour = C_BLUE;
        else if (scan_line > 'h80)  colour = C_YELLOW;
        else if (scan_line > 'h60)  colour = C_MAGENTA;
        else if (scan_line > 'h40)  colour = C_RED;
        else                        colour = C_BLACK;
        // mortar lines between brick rows
        if ((scan_line & 15) < 4)
        begin
            colour = C_BLACK;
        end

        bricks = 8'h00;
        if (scan_line >= 'h40 && scan_line < 'h100)
        begin
            bricks = row_mask[(scan_line - 'h40) >>> 4];
        end

        r = '0;
        g = '0;
        b = '0;
        r[0] = R_LEFT;
        g[0] = G_LEFT;
        b[0] = B_LEFT;
        for (int i = 0; i < 4; i++)
        begin
            pat = (bricks[7] ? BRICK_L : 16'h0000) | (bricks[6] ? BRICK_R : 16'h0000);
            pr = colour[2] ? pat : 16'h0000;
            pg = colour[1] ? pat : 16'h0000;
            pb = colour[0] ? pat : 16'h0000;
            bricks = bricks << 2;
            r[i + 1] = pr;
            g[i] = g[i] | (pg >> 12);
            g[i + 1] = pg << 4;
            b[i] = b[i] | (pb >> 8);
            b[i + 1] = pb << 8;
        end
        r[5] = R_RIGHT;
        g[5] = G_RIGHT;
        b[4] = b[4] | B_RIGHT;
        b[5] = 16'h0000;

        if (scan_line >= 'h200 && scan_line < 'h208)
        begin
            bat_a = int'(c.bat >> 1) + 13;
            r = overlay(r, bat_a, BAT_SHAPE);
            g = overlay(g, bat_a - 4, BAT_SHAPE);
            b = overlay(b, bat_a - 8, BAT_SHAPE);
        end

        by = int'($signed(c.ball_y));
        if (scan_line >= by - 4 && scan_line < by + 4)
        begin
            bx = int'($signed(c.ball_x));
            rx = ((bx + 256) >>> 1) - 128 + 13;
            r = overlay(r, rx, BALL_SHAPE);
            g = overlay(g, rx - 4, BALL_SHAPE);
            b = overlay(b, rx - 8, BALL_SHAPE);
        end

        for (int k = 0; k < NUM_WORDS; k++)
        begin
            wb.idx   = 3'(k);
            wb.red   = r[k];
            wb.green = g[k];
            wb.blue  = b[k];
            wb.last  = (k == NUM_WORDS - 1);
            wb.fe    = fe;
            words_due.push_back(wb);
        end
    endtask

    task automatic apply_cmd(input line_cmd_t c);
        case (c.mode)
            MODE_LINE:    render_line(c);
            MODE_RESTART: scan_line = int'($signed(restart_cfg));
            MODE_BRICK:
            begin
                if (c.row < NUM_ROWS)
                begin
                    row_mask[c.row] = c.bricks;
                end
            end
            default: ;
        endcase
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_FRAME_END)
        begin
            frame_end_cfg = 10'(val);
        end
        else
        begin
            restart_cfg = 7'(val);
        end
    endtask

    task automatic push_cmd(input logic [1:0] m, input logic [6:0] bat, input logic [8:0] bx,
                            input logic [10:0] by, input logic [3:0] row, input logic [7:0] bits);
        line_cmd_t c;
        c.mode   = m;
        c.bat    = bat;
        c.ball_x = bx;
        c.ball_y = by;
        c.row    = row;
        c.bricks = bits;
        cmd_q.push_back(c);
    endtask

    // line tick with the ball aimed near the coming line half of the time
    task automatic push_tick();
        logic [8:0]  bx;
        logic [10:0] by;
        if (stim_line < LINE_TOP)
        begin
            stim_line++;
        end
        bx = $urandom_range(0, 1) ? 9'($urandom) : 9'($urandom_range(0, 154) - 4);
        by = $urandom_range(0, 1) ? 11'(stim_line + $urandom_range(0, 10) - 5) : 11'($urandom);
        push_cmd(MODE_LINE, 7'($urandom_range(0, 127)), bx, by, 4'($urandom), 8'($urandom));
    endtask

    task automatic push_restart();
        stim_line = int'($signed(restart_cfg));
        push_cmd(MODE_RESTART, 7'($urandom), 9'($urandom), 11'($urandom), 4'($urandom),
                 8'($urandom));
    endtask

    task automatic push_mixed(input int restart_pct, input int brick_pct, input int tick_pct);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < restart_pct)
        begin
            push_restart();
        end
        else if (pick < restart_pct + brick_pct)
        begin
            push_cmd(MODE_BRICK, 7'($urandom), 9'($urandom), 11'($urandom),
                     4'($urandom_range(0, 15)), 8'($urandom));
        end
        else if (pick < restart_pct + brick_pct + tick_pct)
        begin
            push_tick();
        end
        else
        begin
            push_cmd(MODE_UNUSED, 7'($urandom), 9'($urandom), 11'($urandom), 4'($urandom),
                     8'($urandom));
        end
    endtask

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (cmd_q.size() > 0 || s_axis_tvalid || words_due.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic wait_sent();
        while (cmd_q.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // input beat accepted: update the predictor
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            apply_cmd(cur_cmd);
            cmd_taken = 1'b1;
        end
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || cmd_taken))
        begin
            cmd_taken = 1'b0;
            if (send_gap > 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() > 0 && $urandom_range(0, 99) < idle_pct)
            begin
                send_gap = $urandom_range(0, 14);
                s_axis_tvalid <= 1'b0;
            end
            else if (cmd_q.size() > 0)
            begin
                cur_cmd = cmd_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {1'b0, cur_cmd.bricks, cur_cmd.row, cur_cmd.ball_y,
                                  cur_cmd.ball_x, cur_cmd.bat};
                s_axis_tuser  <= cur_cmd.mode;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // output back-pressure
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            hold_left = $urandom_range(0, 14);
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // output beat check
    always @(posedge clk)
    begin
        word_beat_t want;
        word_beat_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.idx   = m_axis_tdata[2:0];
            got.red   = m_axis_tdata[18:3];
            got.green = m_axis_tdata[34:19];
            got.blue  = m_axis_tdata[50:35];
            got.last  = m_axis_tlast;
            got.fe    = m_axis_tuser[0];
            if (words_due.size() == 0)
            begin
                bad_beats++;
                if (bad_beats <= 10)
                begin
                    $display("unexpected beat: idx %0d r %h g %h b %h last %b fe %b",
                             got.idx, got.red, got.green, got.blue, got.last, got.fe);
                end
            end
            else
            begin
                want = words_due.pop_front();
                if (got.idx !== want.idx || got.red !== want.red || got.green !== want.green
                    || got.blue !== want.blue || got.last !== want.last || got.fe !== want.fe)
                begin
                    bad_beats++;
                    if (bad_beats <= 10)
                    begin
                        $display("mismatch exp: idx %0d r %h g %h b %h last %b fe %b",
                                 want.idx, want.red, want.green, want.blue, want.last, want.fe);
                        $display("         got: idx %0d r %h g %h b %h last %b fe %b",
                                 got.idx, got.red, got.green, got.blue, got.last, got.fe);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cmd_taken     = 1'b0;
        send_gap      = 0;
        hold_left     = 0;
        idle_pct      = 20;
        bad_beats     = 0;
        cycle_count   = 0;
        scan_line     = 0;
        stim_line     = 0;
        frame_end_cfg = 10'd600;
        restart_cfg   = 7'h64;
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row_mask[i] = 8'hFF;
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, ignored rows, unused mode, restart at its lowest
        set_reg(REG_FRAME_END, 2);
        set_reg(REG_RESTART, -64);
        push_cmd(MODE_LINE, 7'd0, 9'h100, 11'd1, 4'd0, 8'h00);
        push_cmd(MODE_LINE, 7'd127, 9'h0FF, 11'd2, 4'hF, 8'hFF);
        push_cmd(MODE_LINE, 7'd0, 9'd0, 11'h400, 4'd0, 8'h00);
        push_cmd(MODE_LINE, 7'd64, 9'd150, 11'd1023, 4'd0, 8'h00);
        push_cmd(MODE_LINE, 7'd1, 9'h1FC, 11'd5, 4'd0, 8'h00);
        push_cmd(MODE_BRICK, 7'd0, 9'd0, 11'd0, 4'd0, 8'h00);
        push_cmd(MODE_BRICK, 7'd0, 9'd0, 11'd0, 4'd11, 8'hA5);
        push_cmd(MODE_BRICK, 7'd0, 9'd0, 11'd0, 4'd12, 8'h00);
        push_cmd(MODE_BRICK, 7'd0, 9'd0, 11'd0, 4'd15, 8'h0F);
        push_cmd(MODE_UNUSED, 7'h7F, 9'h1FF, 11'h7FF, 4'hF, 8'hFF);
        push_cmd(MODE_RESTART, 7'd0, 9'd0, 11'd0, 4'd0, 8'h00);
        push_cmd(MODE_LINE, 7'd0, 9'h1FF, 11'h7C0, 4'd0, 8'h00);
        push_cmd(MODE_LINE, 7'd127, 9'd0, 11'h7FF, 4'd0, 8'h00);
        push_cmd(MODE_LINE, 7'd33, 9'd77, 11'h7F8, 4'd0, 8'h00);
        push_cmd(MODE_BRICK, 7'd0, 9'd0, 11'd0, 4'd1, 8'h5A);
        wait_idle();

        // sweep from line 0 into the brick band
        set_reg(REG_FRAME_END, 1023);
        set_reg(REG_RESTART, 0);
        push_restart();
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            idle_pct = (chunk % 3 == 2) ? 0 : ((chunk % 3 == 1) ? 30 : 10);
            for (int n = 0; n < 50; n++)
            begin
                push_mixed(0, 4, 94);
            end
            wait_sent();
        end
        wait_idle();

        // random mix with fresh settings
        set_reg(REG_FRAME_END, $urandom_range(64, 300));
        set_reg(REG_RESTART, -$urandom_range(0, 64));
        push_restart();
        for (int chunk = 0; chunk < 4; chunk++)
        begin
            idle_pct = (chunk == 2) ? 0 : 25;
            for (int n = 0; n < 28; n++)
            begin
                push_mixed(2, 12, 80);
            end
            wait_sent();
        end
        idle_pct = 0;
        wait_idle();

        // closing stretch at full rate
        set_reg(REG_FRAME_END, 0);
        set_reg(REG_RESTART, -28);
        push_restart();
        for (int n = 0; n < 40; n++)
        begin
            push_tick();
        end
        wait_idle();

        if (bad_beats == 0 && words_due.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* scanline_bitplane_renderer.f */
+incdir+rtl/core
rtl/core/sbr_pkg.sv
rtl/core/sbr_queue.sv
rtl/core/sbr_front.sv
rtl/core/sbr_back.sv
rtl/core/scanline_bitplane_renderer.sv
bench/tb_scanline_bitplane_renderer.sv
